>>> design/mbpc_pkg.sv
// Shared types, widths and constants for the Mandelbrot pixel colorer.
// No dependencies; used by every module of the block.
package mbpc_pkg;

   // Field widths.
   localparam int ITER_BITS  = 16;
   localparam int PIXEL_BITS = 12;
   localparam int FRAC_BITS  = 28;
   localparam int COORD_BITS = 32;
   localparam int STEP_BITS  = 31;
   localparam int COLOR_BITS = 8;
   localparam int ADDR_BITS  = 5;
   localparam int DATA_BITS  = 32;

   // Pixel mapping: c = min + index * step, held wide enough never to wrap.
   localparam int MAP_BITS = PIXEL_BITS + STEP_BITS;
   localparam int C_BITS   = MAP_BITS + 2;

   // Iteration datapath: magnitudes below 2.0, squares below 4.0, 2*zr*zi below 8.0.
   localparam int MAG_BITS = FRAC_BITS + 1;
   localparam int SQ_BITS  = FRAC_BITS + 2;
   localparam int P_BITS   = FRAC_BITS + 3;
   localparam int Z_BITS   = ((C_BITS > P_BITS) ? C_BITS : P_BITS) + 2;
   localparam logic [P_BITS-1:0] FOUR = P_BITS'(1) << (FRAC_BITS + 2);

   // Color: t = n * 2^24 / max_iter in Q1.24, one quotient bit per divider step.
   localparam int COLOR_FRAC  = 24;
   localparam int T_BITS      = COLOR_FRAC + 1;
   localparam int REM_BITS    = ITER_BITS + 1;
   localparam int DIV_STEPS   = T_BITS;
   localparam int COLOR_STEPS = 10;
   localparam int CNT_BITS    = (DIV_STEPS > COLOR_STEPS) ? $clog2(DIV_STEPS)
                                                          : $clog2(COLOR_STEPS);
   localparam logic [T_BITS-1:0] ONE        = T_BITS'(1) << COLOR_FRAC;
   localparam logic [T_BITS-1:0] RED_GAIN   = T_BITS'(2295);  // 9 * 255
   localparam logic [T_BITS-1:0] GREEN_GAIN = T_BITS'(3825);  // 15 * 255
   localparam logic [T_BITS-1:0] BLUE_GAIN  = T_BITS'(4335);  // 17 * 255, halved later

   // Register map, index = byte address / 4.
   typedef enum logic [2:0] {
      REG_X_MIN    = 3'd0,
      REG_Y_MIN    = 3'd1,
      REG_X_STEP   = 3'd2,
      REG_Y_STEP   = 3'd3,
      REG_MAX_ITER = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x_min;
      logic [COORD_BITS-1:0] y_min;
      logic [STEP_BITS-1:0]  x_step;
      logic [STEP_BITS-1:0]  y_step;
      logic [ITER_BITS-1:0]  max_iter;
   } cfg_type;

   // Shared-multiplier sequence for the color polynomials.
   typedef enum logic [3:0] {
      CS_T2    = 4'd0,
      CS_T3    = 4'd1,
      CS_U2    = 4'd2,
      CS_U3    = 4'd3,
      CS_PR    = 4'd4,
      CS_PG    = 4'd5,
      CS_PB    = 4'd6,
      CS_RED   = 4'd7,
      CS_GREEN = 4'd8,
      CS_BLUE  = 4'd9
   } color_step_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP_MUL,
      ST_MAP_ADD,
      ST_ITER_MUL,
      ST_ITER_ADD,
      ST_DIV,
      ST_COLOR,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic           load_pixel;
      logic           map_mul;
      logic           map_add;
      logic           iter_mul;
      logic           iter_add;
      logic           div_init;
      logic           div_step;
      logic           color_en;
      color_step_type color_step;
      logic           color_clear;
      logic           load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic at_limit;
      logic range_escape;
      logic sum_escape;
      logic iter_zero;
   } dp_status_type;

endpackage

>>> design/mbpc_csr.sv
// Configuration registers behind the APB-style port.
// Depends on mbpc_pkg for the register map and the cfg_type bundle.
module mbpc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mbpc_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [mbpc_pkg::DATA_BITS-1:0] csr_pwdata,
   output logic [mbpc_pkg::DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready,
   output mbpc_pkg::cfg_type             cfg
);

   mbpc_pkg::cfg_type     cfg_ff, cfg_in;
   mbpc_pkg::csr_reg_type reg_sel;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = mbpc_pkg::csr_reg_type'(csr_paddr[mbpc_pkg::ADDR_BITS-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            mbpc_pkg::REG_X_MIN: begin
               cfg_in.x_min = csr_pwdata[mbpc_pkg::COORD_BITS-1:0];
            end
            mbpc_pkg::REG_Y_MIN: begin
               cfg_in.y_min = csr_pwdata[mbpc_pkg::COORD_BITS-1:0];
            end
            mbpc_pkg::REG_X_STEP: begin
               cfg_in.x_step = csr_pwdata[mbpc_pkg::STEP_BITS-1:0];
            end
            mbpc_pkg::REG_Y_STEP: begin
               cfg_in.y_step = csr_pwdata[mbpc_pkg::STEP_BITS-1:0];
            end
            mbpc_pkg::REG_MAX_ITER: begin
               cfg_in.max_iter = csr_pwdata[mbpc_pkg::ITER_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_min    <= mbpc_pkg::COORD_BITS'(32'hE000_0000);
         cfg_ff.y_min    <= mbpc_pkg::COORD_BITS'(32'hE800_0000);
         cfg_ff.x_step   <= mbpc_pkg::STEP_BITS'(786432);
         cfg_ff.y_step   <= mbpc_pkg::STEP_BITS'(786432);
         cfg_ff.max_iter <= mbpc_pkg::ITER_BITS'(256);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         mbpc_pkg::REG_X_MIN: begin
            csr_prdata = mbpc_pkg::DATA_BITS'(cfg_ff.x_min);
         end
         mbpc_pkg::REG_Y_MIN: begin
            csr_prdata = mbpc_pkg::DATA_BITS'(cfg_ff.y_min);
         end
         mbpc_pkg::REG_X_STEP: begin
            csr_prdata = mbpc_pkg::DATA_BITS'(cfg_ff.x_step);
         end
         mbpc_pkg::REG_Y_STEP: begin
            csr_prdata = mbpc_pkg::DATA_BITS'(cfg_ff.y_step);
         end
         mbpc_pkg::REG_MAX_ITER: begin
            csr_prdata = mbpc_pkg::DATA_BITS'(cfg_ff.max_iter);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> design/mbpc_dpath.sv
// Datapath: pixel mapping, z = z^2 + c iteration, restoring divider for t,
// shared multiplier for the color polynomials, and the result register.
// Depends on mbpc_pkg; driven by mbpc_ctrl through dp_cmd_type.
module mbpc_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  mbpc_pkg::cfg_type                cfg,
   input  mbpc_pkg::dp_cmd_type             cmd,
   output mbpc_pkg::dp_status_type          status,
   input  logic [mbpc_pkg::PIXEL_BITS-1:0]  req_pixel_col,
   input  logic [mbpc_pkg::PIXEL_BITS-1:0]  req_pixel_row,
   output logic [mbpc_pkg::COLOR_BITS-1:0]  rsp_red,
   output logic [mbpc_pkg::COLOR_BITS-1:0]  rsp_green,
   output logic [mbpc_pkg::COLOR_BITS-1:0]  rsp_blue,
   output logic [mbpc_pkg::ITER_BITS-1:0]   rsp_iterations
);

   localparam int Z  = mbpc_pkg::Z_BITS;
   localparam int C  = mbpc_pkg::C_BITS;
   localparam int M  = mbpc_pkg::MAG_BITS;
   localparam int SQ = mbpc_pkg::SQ_BITS;
   localparam int P  = mbpc_pkg::P_BITS;
   localparam int T  = mbpc_pkg::T_BITS;
   localparam int F  = mbpc_pkg::FRAC_BITS;
   localparam int CF = mbpc_pkg::COLOR_FRAC;
   localparam int CB = mbpc_pkg::COLOR_BITS;

   // pixel and c
   logic [mbpc_pkg::PIXEL_BITS-1:0] col_ff, row_ff;
   logic [mbpc_pkg::MAP_BITS-1:0]   xprod_ff, yprod_ff, xprod_in, yprod_in;
   logic [C-1:0]                    cr_ff, ci_ff, cr_in, ci_in;

   // iteration state
   logic [Z-1:0]                    zr_ff, zi_ff, zr_in, zi_in;
   logic [mbpc_pkg::ITER_BITS-1:0]  n_ff;
   logic [SQ-1:0]                   sr_ff, si_ff;
   logic [P-1:0]                    p_ff;
   logic                            pneg_ff;

   logic [Z-M-1:0]                  zr_hi, zi_hi;
   logic [M-1:0]                    zr_lo, zi_lo, ar, ai;
   logic                            zr_ok, zi_ok;
   logic [2*M-1:0]                  sq_r, sq_i, sq_ri;
   logic [P-1:0]                    sq_sum;

   // divider
   logic [mbpc_pkg::REM_BITS-1:0]   rem_ff, rem_in, rem_div, rem_diff, rem_sel;
   logic                            rem_ge;
   logic [T-1:0]                    t_ff, t_in, u_val;

   // color
   logic [T-1:0]                    t2_ff, t3_ff, u2_ff, u3_ff, pr_ff, pg_ff, pb_ff;
   logic [CB-1:0]                   red_ff, green_ff, blue_ff;
   logic [T-1:0]                    op_a, op_b;
   logic [2*T-1:0]                  cprod;
   logic [T-1:0]                    cq24;

   // result register
   logic [CB-1:0]                   out_red_ff, out_green_ff, out_blue_ff;
   logic [mbpc_pkg::ITER_BITS-1:0]  out_iter_ff;

   // ---------------- pixel mapping ----------------
   assign xprod_in = {{(mbpc_pkg::MAP_BITS-mbpc_pkg::PIXEL_BITS){1'b0}}, col_ff}
                   * {{(mbpc_pkg::MAP_BITS-mbpc_pkg::STEP_BITS){1'b0}}, cfg.x_step};
   assign yprod_in = {{(mbpc_pkg::MAP_BITS-mbpc_pkg::PIXEL_BITS){1'b0}}, row_ff}
                   * {{(mbpc_pkg::MAP_BITS-mbpc_pkg::STEP_BITS){1'b0}}, cfg.y_step};
   assign cr_in = {{(C-mbpc_pkg::COORD_BITS){cfg.x_min[mbpc_pkg::COORD_BITS-1]}}, cfg.x_min}
                + {{(C-mbpc_pkg::MAP_BITS){1'b0}}, xprod_ff};
   assign ci_in = {{(C-mbpc_pkg::COORD_BITS){cfg.y_min[mbpc_pkg::COORD_BITS-1]}}, cfg.y_min}
                + {{(C-mbpc_pkg::MAP_BITS){1'b0}}, yprod_ff};

   // ---------------- iteration ----------------
   // |z| < 2 check straight on the two's-complement word: upper bits all sign,
   // and for a negative value the low part must not be zero (that is -2.0).
   assign zr_hi = zr_ff[Z-1:M];
   assign zi_hi = zi_ff[Z-1:M];
   assign zr_lo = zr_ff[M-1:0];
   assign zi_lo = zi_ff[M-1:0];
   assign zr_ok = (zr_hi == '0) || ((zr_hi == '1) && (zr_lo != '0));
   assign zi_ok = (zi_hi == '0) || ((zi_hi == '1) && (zi_lo != '0));
   assign ar    = zr_ff[Z-1] ? (~zr_lo + M'(1)) : zr_lo;
   assign ai    = zi_ff[Z-1] ? (~zi_lo + M'(1)) : zi_lo;

   assign sq_r  = {{M{1'b0}}, ar} * {{M{1'b0}}, ar};
   assign sq_i  = {{M{1'b0}}, ai} * {{M{1'b0}}, ai};
   assign sq_ri = {{M{1'b0}}, ar} * {{M{1'b0}}, ai};

   assign sq_sum = {1'b0, sr_ff} + {1'b0, si_ff};

   assign zr_in = {{(Z-C){cr_ff[C-1]}}, cr_ff}
                + {{(Z-SQ){1'b0}}, sr_ff}
                - {{(Z-SQ){1'b0}}, si_ff};
   assign zi_in = pneg_ff ? ({{(Z-C){ci_ff[C-1]}}, ci_ff} - {{(Z-P){1'b0}}, p_ff})
                          : ({{(Z-C){ci_ff[C-1]}}, ci_ff} + {{(Z-P){1'b0}}, p_ff});

   assign status.at_limit     = (n_ff >= cfg.max_iter);
   assign status.range_escape = !(zr_ok && zi_ok);
   assign status.sum_escape   = (sq_sum >= mbpc_pkg::FOUR);
   assign status.iter_zero    = (cfg.max_iter == '0);

   // ---------------- divider: t = n * 2^24 / max_iter ----------------
   assign rem_div  = {1'b0, cfg.max_iter};
   assign rem_ge   = (rem_ff >= rem_div);
   assign rem_diff = rem_ff - rem_div;
   assign rem_sel  = rem_ge ? rem_diff : rem_ff;
   assign rem_in   = {rem_sel[mbpc_pkg::REM_BITS-2:0], 1'b0};
   assign t_in     = {t_ff[T-2:0], rem_ge};
   assign u_val    = mbpc_pkg::ONE - t_ff;

   // ---------------- color: one product per step ----------------
   always_comb begin
      case (cmd.color_step)
         mbpc_pkg::CS_T2: begin
            op_a = t_ff;  op_b = t_ff;
         end
         mbpc_pkg::CS_T3: begin
            op_a = t2_ff; op_b = t_ff;
         end
         mbpc_pkg::CS_U2: begin
            op_a = u_val; op_b = u_val;
         end
         mbpc_pkg::CS_U3: begin
            op_a = u2_ff; op_b = u_val;
         end
         mbpc_pkg::CS_PR: begin
            op_a = u_val; op_b = t3_ff;
         end
         mbpc_pkg::CS_PG: begin
            op_a = u2_ff; op_b = t2_ff;
         end
         mbpc_pkg::CS_PB: begin
            op_a = u3_ff; op_b = t_ff;
         end
         mbpc_pkg::CS_RED: begin
            op_a = pr_ff; op_b = mbpc_pkg::RED_GAIN;
         end
         mbpc_pkg::CS_GREEN: begin
            op_a = pg_ff; op_b = mbpc_pkg::GREEN_GAIN;
         end
         mbpc_pkg::CS_BLUE: begin
            op_a = pb_ff; op_b = mbpc_pkg::BLUE_GAIN;
         end
         default: begin
            op_a = '0;    op_b = '0;
         end
      endcase
   end

   assign cprod = {{T{1'b0}}, op_a} * {{T{1'b0}}, op_b};
   assign cq24  = cprod[CF +: T];

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         col_ff <= req_pixel_col;
         row_ff <= req_pixel_row;
      end
      if (cmd.map_mul) begin
         xprod_ff <= xprod_in;
         yprod_ff <= yprod_in;
      end
      if (cmd.map_add) begin
         cr_ff <= cr_in;
         ci_ff <= ci_in;
         zr_ff <= '0;
         zi_ff <= '0;
         n_ff  <= '0;
      end else if (cmd.iter_add) begin
         zr_ff <= zr_in;
         zi_ff <= zi_in;
         n_ff  <= n_ff + mbpc_pkg::ITER_BITS'(1);
      end
      if (cmd.iter_mul) begin
         sr_ff   <= sq_r[2*M-1:F];
         si_ff   <= sq_i[2*M-1:F];
         p_ff    <= sq_ri[2*M-1:F-1];
         pneg_ff <= zr_ff[Z-1] ^ zi_ff[Z-1];
      end
      if (cmd.div_init) begin
         rem_ff <= {1'b0, n_ff};
         t_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         t_ff   <= t_in;
      end
      if (cmd.color_clear) begin
         red_ff   <= '0;
         green_ff <= '0;
         blue_ff  <= '0;
      end else if (cmd.color_en) begin
         case (cmd.color_step)
            mbpc_pkg::CS_T2:    t2_ff    <= cq24;
            mbpc_pkg::CS_T3:    t3_ff    <= cq24;
            mbpc_pkg::CS_U2:    u2_ff    <= cq24;
            mbpc_pkg::CS_U3:    u3_ff    <= cq24;
            mbpc_pkg::CS_PR:    pr_ff    <= cq24;
            mbpc_pkg::CS_PG:    pg_ff    <= cq24;
            mbpc_pkg::CS_PB:    pb_ff    <= cq24;
            mbpc_pkg::CS_RED:   red_ff   <= cq24[CB-1:0];
            mbpc_pkg::CS_GREEN: green_ff <= cq24[CB-1:0];
            // blue carries the extra halving of 8.5 = 17 / 2
            mbpc_pkg::CS_BLUE:  blue_ff  <= cprod[CF+1 +: CB];
            default: begin
               red_ff <= red_ff;
            end
         endcase
      end
      if (cmd.load_out) begin
         out_red_ff   <= red_ff;
         out_green_ff <= green_ff;
         out_blue_ff  <= blue_ff;
         out_iter_ff  <= n_ff;
      end
   end

   assign rsp_red        = out_red_ff;
   assign rsp_green      = out_green_ff;
   assign rsp_blue       = out_blue_ff;
   assign rsp_iterations = out_iter_ff;

   // ---------------- checks ----------------
   a_iter_below_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.iter_add |-> (n_ff < cfg.max_iter))
      else $error("iteration step issued at or past the limit");

   a_div_after_iter: assert property (@(posedge clock) disable iff (reset)
      cmd.div_init |-> !status.iter_zero)
      else $error("divider started with a zero iteration limit");

endmodule

>>> design/mbpc_ctrl.sv
// Sequencer: handshakes, iteration loop, divider and color step counts.
// Depends on mbpc_pkg; commands mbpc_dpath through dp_cmd_type.
module mbpc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  mbpc_pkg::dp_status_type   status,
   output mbpc_pkg::dp_cmd_type      cmd
);

   localparam logic [mbpc_pkg::CNT_BITS-1:0] DIV_LAST =
      mbpc_pkg::CNT_BITS'(mbpc_pkg::DIV_STEPS - 1);
   localparam logic [mbpc_pkg::CNT_BITS-1:0] COLOR_LAST =
      mbpc_pkg::CNT_BITS'(mbpc_pkg::COLOR_STEPS - 1);

   mbpc_pkg::state_type              state_ff, state_in;
   logic [mbpc_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             loop_exit, out_free;

   assign loop_exit = status.at_limit || status.range_escape;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mbpc_pkg::ST_IDLE: begin
            if (req_valid) state_in = mbpc_pkg::ST_MAP_MUL;
         end
         mbpc_pkg::ST_MAP_MUL: begin
            state_in = mbpc_pkg::ST_MAP_ADD;
         end
         mbpc_pkg::ST_MAP_ADD: begin
            state_in = mbpc_pkg::ST_ITER_MUL;
         end
         mbpc_pkg::ST_ITER_MUL: begin
            if (!loop_exit)            state_in = mbpc_pkg::ST_ITER_ADD;
            else if (status.iter_zero) state_in = mbpc_pkg::ST_RESULT;
            else                       state_in = mbpc_pkg::ST_DIV;
         end
         mbpc_pkg::ST_ITER_ADD: begin
            state_in = status.sum_escape ? mbpc_pkg::ST_DIV : mbpc_pkg::ST_ITER_MUL;
         end
         mbpc_pkg::ST_DIV: begin
            if (cnt_ff == DIV_LAST) state_in = mbpc_pkg::ST_COLOR;
         end
         mbpc_pkg::ST_COLOR: begin
            if (cnt_ff == COLOR_LAST) state_in = mbpc_pkg::ST_RESULT;
         end
         mbpc_pkg::ST_RESULT: begin
            if (out_free) state_in = mbpc_pkg::ST_IDLE;
         end
         default: begin
            state_in = mbpc_pkg::ST_IDLE;
         end
      endcase
   end

   // step counter, shared by the divider and the color sequence
   always_comb begin
      case (state_ff)
         mbpc_pkg::ST_DIV: begin
            cnt_in = (cnt_ff == DIV_LAST) ? '0 : cnt_ff + mbpc_pkg::CNT_BITS'(1);
         end
         mbpc_pkg::ST_COLOR: begin
            cnt_in = cnt_ff + mbpc_pkg::CNT_BITS'(1);
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         mbpc_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.load_pixel = req_valid;
         end
         mbpc_pkg::ST_MAP_MUL: begin
            cmd.map_mul = 1'b1;
         end
         mbpc_pkg::ST_MAP_ADD: begin
            cmd.map_add = 1'b1;
         end
         mbpc_pkg::ST_ITER_MUL: begin
            cmd.iter_mul    = !loop_exit;
            cmd.div_init    = loop_exit && !status.iter_zero;
            cmd.color_clear = loop_exit && status.iter_zero;
         end
         mbpc_pkg::ST_ITER_ADD: begin
            cmd.iter_add = !status.sum_escape;
            cmd.div_init = status.sum_escape;
         end
         mbpc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         mbpc_pkg::ST_COLOR: begin
            cmd.color_en   = 1'b1;
            cmd.color_step = mbpc_pkg::color_step_type'(cnt_ff[3:0]);
         end
         mbpc_pkg::ST_RESULT: begin
            cmd.load_out = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // result valid: set on load, cleared on transfer
   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbpc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");

   a_valid_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == mbpc_pkg::ST_RESULT))
      else $error("result valid raised outside the result state");

   a_div_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbpc_pkg::ST_DIV) |-> (cnt_ff <= DIV_LAST))
      else $error("divider step count out of range");

   a_color_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbpc_pkg::ST_COLOR) |-> (cnt_ff <= COLOR_LAST))
      else $error("color step count out of range");

endmodule

>>> design/mandelbrot_pixel_color.sv
// Top level of the Mandelbrot escape-time pixel colorer.
// Depends on mbpc_pkg, mbpc_csr, mbpc_ctrl and mbpc_dpath.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  pixel_col, pixel_row
//   rsp      out        rsp_valid/rsp_ready  red, green, blue, iterations
//   csr      in/out     APB psel/penable     x_min, y_min, x_step, y_step, max_iter
//
// One pixel at a time. Each iteration passes through the squaring multipliers and
// then the z update adders. Once the limit, the range check or the |z|^2 test
// ends the loop, the divider forms t and the shared color multiplier the colors;
// a zero limit skips both.
// Reset is synchronous; it clears the sequencer and loads the default registers.
// A held result does not stop the next pixel from being taken and worked on;
// only its final load waits for the result register to be free.
module mandelbrot_pixel_color (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mbpc_pkg::PIXEL_BITS-1:0] req_pixel_col,
   input  logic [mbpc_pkg::PIXEL_BITS-1:0] req_pixel_row,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mbpc_pkg::COLOR_BITS-1:0] rsp_red,
   output logic [mbpc_pkg::COLOR_BITS-1:0] rsp_green,
   output logic [mbpc_pkg::COLOR_BITS-1:0] rsp_blue,
   output logic [mbpc_pkg::ITER_BITS-1:0]  rsp_iterations,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mbpc_pkg::ADDR_BITS-1:0]  csr_paddr,
   input  logic [mbpc_pkg::DATA_BITS-1:0]  csr_pwdata,
   output logic [mbpc_pkg::DATA_BITS-1:0]  csr_prdata,
   output logic                            csr_pready
);

   mbpc_pkg::cfg_type       cfg;
   mbpc_pkg::dp_cmd_type    cmd;
   mbpc_pkg::dp_status_type status;

   mbpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mbpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mbpc_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_iterations (rsp_iterations)
   );

endmodule

>>> tb/sv/mandelbrot_pixel_color_tb.sv
// Self-checking testbench for mandelbrot_pixel_color: directed and random pixels
// over several views, each result checked against a local escape-time color predictor.
// Depends on mbpc_pkg and the mandelbrot_pixel_color RTL.
`timescale 1ns / 100ps

module mandelbrot_pixel_color_tb;

   localparam int STALL_LIMIT = 400000;
   localparam logic [2:0] REG_SPARE = 3'd5;  // index with no register behind it
   localparam longint unsigned ESC_MAG = 64'd2 << mbpc_pkg::FRAC_BITS;
   localparam longint unsigned ESC_SUM = 64'd4 << mbpc_pkg::FRAC_BITS;
   localparam longint unsigned T_ONE = 64'd1 << mbpc_pkg::COLOR_FRAC;

   typedef struct {
      logic [mbpc_pkg::COLOR_BITS-1:0] red;
      logic [mbpc_pkg::COLOR_BITS-1:0] green;
      logic [mbpc_pkg::COLOR_BITS-1:0] blue;
      logic [mbpc_pkg::ITER_BITS-1:0]  iterations;
   } pixel_color_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [mbpc_pkg::PIXEL_BITS-1:0] req_pixel_col = '0;
   logic [mbpc_pkg::PIXEL_BITS-1:0] req_pixel_row = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [mbpc_pkg::COLOR_BITS-1:0] rsp_red;
   logic [mbpc_pkg::COLOR_BITS-1:0] rsp_green;
   logic [mbpc_pkg::COLOR_BITS-1:0] rsp_blue;
   logic [mbpc_pkg::ITER_BITS-1:0]  rsp_iterations;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [mbpc_pkg::ADDR_BITS-1:0]  csr_paddr = '0;
   logic [mbpc_pkg::DATA_BITS-1:0]  csr_pwdata = '0;
   logic [mbpc_pkg::DATA_BITS-1:0]  csr_prdata;
   logic                            csr_pready;

   mbpc_pkg::cfg_type view_cfg;
   pixel_color_type   pending_colors[$];
   int                mismatch_count = 0;
   int                stall_cycles = 0;
   int                sender_idle_pct = 17;
   int                receiver_idle_pct = 64;

   mandelbrot_pixel_color uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_iterations (rsp_iterations),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #10 clock = ~clock;

   // Q1.24 product, truncated
   function automatic longint unsigned color_mul(longint unsigned a, longint unsigned b);
      return (a * b) >> mbpc_pkg::COLOR_FRAC;
   endfunction

   function automatic pixel_color_type predict_pixel_color(
         logic [mbpc_pkg::PIXEL_BITS-1:0] col,
         logic [mbpc_pkg::PIXEL_BITS-1:0] row);
      pixel_color_type res;
      longint          cr, ci, zr, zi, nr, ni;
      longint unsigned ar, ai, sr, si, p, t, u, t2, t3, u2, u3;
      int unsigned     n;
      cr = longint'($signed(view_cfg.x_min)) + longint'(col) * longint'(view_cfg.x_step);
      ci = longint'($signed(view_cfg.y_min)) + longint'(row) * longint'(view_cfg.y_step);
      zr = 0;
      zi = 0;
      n = 0;
      while (n < view_cfg.max_iter) begin
         ar = (zr < 0) ? -zr : zr;
         ai = (zi < 0) ? -zi : zi;
         if (ar >= ESC_MAG || ai >= ESC_MAG) break;
         sr = (ar * ar) >> mbpc_pkg::FRAC_BITS;
         si = (ai * ai) >> mbpc_pkg::FRAC_BITS;
         if (sr + si >= ESC_SUM) break;
         p = (ar * ai) >> (mbpc_pkg::FRAC_BITS - 1);
         nr = longint'(sr) - longint'(si) + cr;
         // sign of 2*zr*zi comes from the old z
         ni = ((zr < 0) != (zi < 0)) ? ci - longint'(p) : ci + longint'(p);
         zr = nr;
         zi = ni;
         n++;
      end
      res.iterations = n[mbpc_pkg::ITER_BITS-1:0];
      res.red = '0;
      res.green = '0;
      res.blue = '0;
      if (view_cfg.max_iter != 0) begin
         t = (64'(n) << mbpc_pkg::COLOR_FRAC) / 64'(view_cfg.max_iter);
         if (t > T_ONE) t = T_ONE;
         u = T_ONE - t;
         t2 = color_mul(t, t);
         t3 = color_mul(t2, t);
         u2 = color_mul(u, u);
         u3 = color_mul(u2, u);
         res.red   = mbpc_pkg::COLOR_BITS'((color_mul(u, t3) * 64'(mbpc_pkg::RED_GAIN))
                     >> mbpc_pkg::COLOR_FRAC);
         res.green = mbpc_pkg::COLOR_BITS'((color_mul(u2, t2) * 64'(mbpc_pkg::GREEN_GAIN))
                     >> mbpc_pkg::COLOR_FRAC);
         res.blue  = mbpc_pkg::COLOR_BITS'((color_mul(u3, t) * 64'(mbpc_pkg::BLUE_GAIN))
                     >> (mbpc_pkg::COLOR_FRAC + 1));
      end
      return res;
   endfunction

   always @(negedge clock) rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);

   always @(posedge clock) begin : check_colors
      pixel_color_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_colors.size() == 0) begin
            $error("result transfer with no pixel outstanding");
            mismatch_count++;
         end else begin
            want = pending_colors.pop_front();
            if (rsp_red !== want.red) begin
               $error("red expected %0d actual %0d", want.red, rsp_red);
               mismatch_count++;
            end
            if (rsp_green !== want.green) begin
               $error("green expected %0d actual %0d", want.green, rsp_green);
               mismatch_count++;
            end
            if (rsp_blue !== want.blue) begin
               $error("blue expected %0d actual %0d", want.blue, rsp_blue);
               mismatch_count++;
            end
            if (rsp_iterations !== want.iterations) begin
               $error("iterations expected %0d actual %0d", want.iterations, rsp_iterations);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx,
                            input logic [mbpc_pkg::DATA_BITS-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         mbpc_pkg::REG_X_MIN:    view_cfg.x_min = value;
         mbpc_pkg::REG_Y_MIN:    view_cfg.y_min = value;
         mbpc_pkg::REG_X_STEP:   view_cfg.x_step = value[mbpc_pkg::STEP_BITS-1:0];
         mbpc_pkg::REG_Y_STEP:   view_cfg.y_step = value[mbpc_pkg::STEP_BITS-1:0];
         mbpc_pkg::REG_MAX_ITER: view_cfg.max_iter = value[mbpc_pkg::ITER_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // drop valid, let every outstanding pixel come back, then let the block settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_view(input logic [31:0] xmin, input logic [31:0] ymin,
                               input logic [31:0] xstep, input logic [31:0] ystep,
                               input logic [31:0] maxit);
      wait_idle();
      csr_write(mbpc_pkg::REG_X_MIN, xmin);
      csr_write(mbpc_pkg::REG_Y_MIN, ymin);
      csr_write(mbpc_pkg::REG_X_STEP, xstep);
      csr_write(mbpc_pkg::REG_Y_STEP, ystep);
      csr_write(mbpc_pkg::REG_MAX_ITER, maxit);
   endtask

   task automatic send_pixel(input logic [mbpc_pkg::PIXEL_BITS-1:0] col,
                             input logic [mbpc_pkg::PIXEL_BITS-1:0] row);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_col <= col;
      req_pixel_row <= row;
      do @(posedge clock); while (!req_ready);
      pending_colors.push_back(predict_pixel_color(col, row));
   endtask

   // reset view: -2.0 - 1.5i, step 3/1024; (683,512) sits next to the origin
   task automatic test_default_view();
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd683, 12'd512);
   endtask

   // step 1/1024 from the origin: range escape, sum escape, boundary at 2
   task automatic test_escape_paths();
      program_view(32'd0, 32'd0, 32'd262144, 32'd262144, 32'd64);
      send_pixel(12'd486, 12'd0);
      send_pixel(12'd384, 12'd384);
      send_pixel(12'd512, 12'd512);
      send_pixel(12'd0, 12'd512);
      send_pixel(12'd4095, 12'd4095);
   endtask

   task automatic test_zero_limit();
      program_view(32'hE000_0000, 32'hE800_0000, 32'd786432, 32'd786432, 32'd0);
      send_pixel(12'd683, 12'd512);
      send_pixel(12'd4095, 12'd0);
   endtask

   // coordinate extremes, stray upper step bit, write to an unmapped index
   task automatic test_far_points();
      program_view(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd20);
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd0, 12'd4095);
   endtask

   // c = 0 never escapes, so the count runs to the limit
   task automatic test_limit_extremes();
      program_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
      send_pixel(12'd0, 12'd0);
      program_view(32'd0, 32'd0, 32'd0, 32'd0, 32'h0000_FFFF);
      send_pixel(12'd0, 12'd0);
      program_view(32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_0003);
      send_pixel(12'd4095, 12'd4095);
   endtask

   task automatic test_random_views();
      logic [31:0] xmin, ymin, xstep, ystep, maxit;
      int          pick;
      for (int phase = 0; phase < 3; phase++) begin
         for (int v = 0; v < 11; v++) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
               // window somewhere over the set: re in [-2.5, 1.0], im in [-1.5, 1.5]
               xmin = -32'sd671088640 + $urandom_range(0, 939524096);
               ymin = -32'sd402653184 + $urandom_range(0, 805306368);
               xstep = (pick < 3) ? $urandom_range(0, 4096) : $urandom_range(0, 262144);
               ystep = (pick < 3) ? $urandom_range(0, 4096) : $urandom_range(0, 262144);
            end else begin
               xmin = $urandom;
               ymin = $urandom;
               xstep = $urandom;
               ystep = $urandom;
            end
            pick = $urandom_range(0, 19);
            if (pick < 14) maxit = $urandom_range(1, 48);
            else if (pick < 19) maxit = $urandom_range(49, 300);
            else maxit = {16'($urandom), 16'($urandom_range(1, 48))};
            program_view(xmin, ymin, xstep, ystep, maxit);
            if (phase == 0) begin
               sender_idle_pct = 17;
               receiver_idle_pct = 64;
            end else if (phase == 1) begin
               sender_idle_pct = 64;
               receiver_idle_pct = 17;
            end else begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
            repeat (49) send_pixel(12'($urandom), 12'($urandom));
         end
      end
   endtask

   initial begin
      view_cfg.x_min = 32'hE000_0000;
      view_cfg.y_min = 32'hE800_0000;
      view_cfg.x_step = 31'd786432;
      view_cfg.y_step = 31'd786432;
      view_cfg.max_iter = 16'd256;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_view();
      test_escape_paths();
      test_zero_limit();
      test_far_points();
      test_limit_extremes();
      test_random_views();
      wait_idle();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> files.f
design/mbpc_pkg.sv
design/mbpc_csr.sv
design/mbpc_dpath.sv
design/mbpc_ctrl.sv
design/mandelbrot_pixel_color.sv
tb/sv/mandelbrot_pixel_color_tb.sv
